### sv/uafs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uafs_pkg
// Shared types and constants of the UART frame serializer: register codes,
// frame descriptor passed from the front end to the serializer, hold times.
// ----------------------------------------------------------------------------
package uafs_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_START_BITS = 2'd0,
        REG_DATA_BITS  = 2'd1,
        REG_STOP_BITS  = 2'd2,
        REG_BAUD_RATE  = 2'd3
    } cfg_reg_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SEND
    } back_state_t;

    localparam int CFG_DATA_W = 17;
    localparam int HOLD_W     = 17;
    localparam int IDX_W      = 4;   // period index, frames hold at most 16 periods

    localparam logic [2:0]  EDGE_BITS_MAX  = 3'd4;
    localparam logic [2:0]  RST_START_BITS = 3'd1;
    localparam logic [3:0]  RST_DATA_BITS  = 4'd8;
    localparam logic [2:0]  RST_STOP_BITS  = 3'd1;
    localparam logic [16:0] RST_BAUD_RATE  = 17'd19200;

    localparam logic [16:0] BAUD_9600  = 17'd9600;
    localparam logic [16:0] BAUD_19200 = 17'd19200;
    localparam logic [16:0] BAUD_28800 = 17'd28800;
    localparam logic [16:0] HOLD_9600  = 17'd104000;
    localparam logic [16:0] HOLD_19200 = 17'd51000;
    localparam logic [16:0] HOLD_28800 = 17'd33300;

    // One frame as the serializer needs it
    typedef struct packed {
        logic [7:0]        data;
        logic [2:0]        start_end;  // first data period
        logic [3:0]        data_end;   // first stop period
        logic [IDX_W-1:0]  last_idx;   // index of the final period
        logic [HOLD_W-1:0] hold;
    } desc_t;

endpackage

### sv/uart_frame_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_frame_serializer
// UART transmitter with inverted line: turns each byte into a run of bit
// periods (start, data LSB first, stop), each with a level and hold time.
// ----------------------------------------------------------------------------
// A frame's first period reaches the result ports through the queue slot,
//   the serializer's descriptor register and the output register.
// A frame has 3 to 16 periods; the serializer loads each frame in its idle
//   state, then emits one period per cycle while the output slot is free.
// Two frame descriptors buffer between byte intake and the serializer.
// Reset (rst_n low, asynchronous) empties queue and output, restores defaults.
// ----------------------------------------------------------------------------
module uart_frame_serializer #(
    parameter int MAX_DATA_BITS  = 8,
    parameter int MAX_FRAME_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  tx_byte,
    output logic        empty,
    input  logic        pop,
    output logic        line_level,
    output logic [16:0] hold_ns,
    output logic        frame_end
);

    logic            q_wr;
    logic            q_full;
    logic            q_rd;
    logic            q_empty;
    uafs_pkg::desc_t wr_desc;
    uafs_pkg::desc_t rd_desc;

    uafs_front #(
        .MAX_DATA_BITS  (MAX_DATA_BITS),
        .MAX_FRAME_BITS (MAX_FRAME_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .tx_byte   (tx_byte),
        .q_full    (q_full),
        .q_wr      (q_wr),
        .q_desc    (wr_desc)
    );

    uafs_queue #(
        .DEPTH (2)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_desc (wr_desc),
        .q_full  (q_full),
        .rd      (q_rd),
        .rd_desc (rd_desc),
        .q_empty (q_empty)
    );

    uafs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_desc     (rd_desc),
        .q_rd       (q_rd),
        .empty      (empty),
        .pop        (pop),
        .line_level (line_level),
        .hold_ns    (hold_ns),
        .frame_end  (frame_end)
    );

endmodule

### sv/uafs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uafs_front
// Configuration registers and frame classification: clamps the bit counts,
// picks the hold time and writes one descriptor per byte into the queue.
// ----------------------------------------------------------------------------
module uafs_front #(
    parameter int MAX_DATA_BITS  = 8,
    parameter int MAX_FRAME_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [uafs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    tx_byte,
    input  logic                          q_full,
    output logic                          q_wr,
    output uafs_pkg::desc_t               q_desc
);

    localparam logic [3:0] ND_MAX    = 4'(MAX_DATA_BITS);
    localparam logic [4:0] FRAME_MAX = 5'(MAX_FRAME_BITS);

    logic [2:0]  start_bits_reg;
    logic [3:0]  data_bits_reg;
    logic [2:0]  stop_bits_reg;
    logic [16:0] baud_rate_reg;

    logic [2:0]  ns;
    logic [3:0]  nd;
    logic [2:0]  np;
    logic [4:0]  total;
    logic [4:0]  total_cl;
    logic [16:0] hold;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_bits_reg <= uafs_pkg::RST_START_BITS;
            data_bits_reg  <= uafs_pkg::RST_DATA_BITS;
            stop_bits_reg  <= uafs_pkg::RST_STOP_BITS;
            baud_rate_reg  <= uafs_pkg::RST_BAUD_RATE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (uafs_pkg::cfg_reg_t'(cfg_index))
                uafs_pkg::REG_START_BITS: start_bits_reg <= cfg_data[2:0];
                uafs_pkg::REG_DATA_BITS:  data_bits_reg  <= cfg_data[3:0];
                uafs_pkg::REG_STOP_BITS:  stop_bits_reg  <= cfg_data[2:0];
                uafs_pkg::REG_BAUD_RATE:  baud_rate_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Zero counts act as one, oversized counts saturate
    always_comb
    begin
        if (start_bits_reg == 3'd0)
            ns = 3'd1;
        else if (start_bits_reg > uafs_pkg::EDGE_BITS_MAX)
            ns = uafs_pkg::EDGE_BITS_MAX;
        else
            ns = start_bits_reg;

        if (data_bits_reg == 4'd0)
            nd = 4'd1;
        else if (data_bits_reg > ND_MAX)
            nd = ND_MAX;
        else
            nd = data_bits_reg;

        if (stop_bits_reg == 3'd0)
            np = 3'd1;
        else if (stop_bits_reg > uafs_pkg::EDGE_BITS_MAX)
            np = uafs_pkg::EDGE_BITS_MAX;
        else
            np = stop_bits_reg;

        total    = 5'(ns) + 5'(nd) + 5'(np);
        total_cl = (total > FRAME_MAX) ? FRAME_MAX : total;

        case (baud_rate_reg)
            uafs_pkg::BAUD_9600:  hold = uafs_pkg::HOLD_9600;
            uafs_pkg::BAUD_19200: hold = uafs_pkg::HOLD_19200;
            uafs_pkg::BAUD_28800: hold = uafs_pkg::HOLD_28800;
            default:              hold = uafs_pkg::HOLD_19200;
        endcase
    end

    assign full = q_full;
    assign q_wr = push && !q_full;

    always_comb
    begin
        q_desc.data      = tx_byte;
        q_desc.start_end = ns;
        q_desc.data_end  = 4'(ns) + nd;
        q_desc.last_idx  = 4'(total_cl - 5'd1);
        q_desc.hold      = hold;
    end

endmodule

### sv/uafs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uafs_queue
// Short descriptor queue between the front end and the serializer.
// ----------------------------------------------------------------------------
module uafs_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr,
    input  uafs_pkg::desc_t wr_desc,
    output logic            q_full,
    input  logic            rd,
    output uafs_pkg::desc_t rd_desc,
    output logic            q_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    uafs_pkg::desc_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic do_wr;
    logic do_rd;

    assign q_full  = (count_reg == CNT_FULL);
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rd_desc = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_desc;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

    a_ptr_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CNT_FULL) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers out of step with count");

endmodule

### sv/uafs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uafs_back
// Serializer: walks one frame descriptor period by period into an output
// register that the consumer drains.
// ----------------------------------------------------------------------------
module uafs_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  uafs_pkg::desc_t             q_desc,
    output logic                        q_rd,
    output logic                        empty,
    input  logic                        pop,
    output logic                        line_level,
    output logic [uafs_pkg::HOLD_W-1:0] hold_ns,
    output logic                        frame_end
);

    uafs_pkg::back_state_t state_reg, state_next;
    uafs_pkg::desc_t       desc_reg, desc_next;
    logic [uafs_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        line_reg, line_next;
    logic [uafs_pkg::HOLD_W-1:0] hold_reg, hold_next;
    logic                        end_reg, end_next;

    logic       out_free;
    logic       is_last;
    logic       level;
    logic [3:0] data_off;

    assign out_free = !out_valid_reg || pop;
    assign is_last  = (idx_reg == desc_reg.last_idx);
    assign data_off = idx_reg - 4'(desc_reg.start_end);

    always_comb
    begin
        if (idx_reg < 4'(desc_reg.start_end))
            level = 1'b1;
        else if (idx_reg < desc_reg.data_end)
            level = ~desc_reg.data[data_off[2:0]];
        else
            level = 1'b0;
    end

    always_comb
    begin
        state_next     = state_reg;
        desc_next      = desc_reg;
        idx_next       = idx_reg;
        q_rd           = 1'b0;
        out_valid_next = out_valid_reg && !pop;
        line_next      = line_reg;
        hold_next      = hold_reg;
        end_next       = end_reg;
        case (state_reg)
            uafs_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_rd       = 1'b1;
                    desc_next  = q_desc;
                    idx_next   = '0;
                    state_next = uafs_pkg::ST_SEND;
                end
            end
            uafs_pkg::ST_SEND:
            begin
                // advance one period whenever the output slot frees up
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    line_next      = level;
                    hold_next      = desc_reg.hold;
                    end_next       = is_last;
                    if (is_last)
                        state_next = uafs_pkg::ST_IDLE;
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = uafs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= uafs_pkg::ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
        line_reg <= line_next;
        hold_reg <= hold_next;
        end_reg  <= end_next;
    end

    assign empty      = !out_valid_reg;
    assign line_level = line_reg;
    assign hold_ns    = hold_reg;
    assign frame_end  = end_reg;

    a_idx_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == uafs_pkg::ST_SEND) |-> (idx_reg <= desc_reg.last_idx))
        else $error("period index past end of frame");

    a_load_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_rd |-> (state_reg == uafs_pkg::ST_IDLE && !q_empty))
        else $error("descriptor taken while a frame is in progress");

    a_frame_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == uafs_pkg::ST_SEND && out_free && is_last)
            |=> (state_reg == uafs_pkg::ST_IDLE && out_valid_reg && frame_end))
        else $error("final period not marked as frame end");

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for uart_frame_serializer. A table of directed bytes and
// register writes runs first, then random phases with new register settings.
// Every accepted byte is expanded into its expected bit periods, and each
// popped period is compared against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DATA_BITS_CAP  = 8;
    localparam int FRAME_CAP      = 16;
    localparam int TOTAL_ITEMS    = 310;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct packed {
        logic        level;
        logic [16:0] hold;
        logic        last;
    } period_t;

    typedef enum logic {
        ROW_CFG,
        ROW_BYTE
    } row_op_t;

    typedef struct {
        row_op_t              op;
        uafs_pkg::cfg_reg_t   reg_idx;
        logic [16:0]          value;
        bit                   typed;
        int                   len;
        logic [15:0]          levels;
        logic [16:0]          hold;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [16:0] cfg_data = '0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  tx_byte = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic        line_level;
    logic [16:0] hold_ns;
    logic        frame_end;

    // Register copies for the frame predictor
    logic [2:0]  frm_start_bits;
    logic [3:0]  frm_data_bits;
    logic [2:0]  frm_stop_bits;
    logic [16:0] frm_baud_rate;

    period_t     expected_periods[$];
    stim_row_t   directed_rows[$];
    int          mismatch_count = 0;
    int          bytes_sent = 0;
    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;
    bit          hold_req = 1'b0;

    uart_frame_serializer i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .tx_byte    (tx_byte),
        .empty      (empty),
        .pop        (pop),
        .line_level (line_level),
        .hold_ns    (hold_ns),
        .frame_end  (frame_end)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic int clamp_count(input int v, input int hi);
        if (v < 1)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    // Expand one byte into the bit periods of its frame
    function automatic void predict_frame(input logic [7:0] b);
        int          n_start;
        int          n_data;
        int          n_stop;
        int          total;
        logic [16:0] hold;
        period_t     p;
        n_start = clamp_count(int'(frm_start_bits), int'(uafs_pkg::EDGE_BITS_MAX));
        n_data  = clamp_count(int'(frm_data_bits), DATA_BITS_CAP);
        n_stop  = clamp_count(int'(frm_stop_bits), int'(uafs_pkg::EDGE_BITS_MAX));
        total   = n_start + n_data + n_stop;
        if (total > FRAME_CAP)
            total = FRAME_CAP;
        case (frm_baud_rate)
            uafs_pkg::BAUD_9600:  hold = uafs_pkg::HOLD_9600;
            uafs_pkg::BAUD_28800: hold = uafs_pkg::HOLD_28800;
            default:              hold = uafs_pkg::HOLD_19200;
        endcase
        for (int k = 0; k < total; k++)
        begin
            if (k < n_start)
                p.level = 1'b1;
            else if (k < n_start + n_data)
                p.level = ~b[(k - n_start) & 7];
            else
                p.level = 1'b0;
            p.hold = hold;
            p.last = (k == total - 1);
            expected_periods.push_back(p);
        end
    endfunction

    function automatic void add_cfg(input uafs_pkg::cfg_reg_t idx, input logic [16:0] val);
        stim_row_t r;
        r = '{op: ROW_CFG, reg_idx: idx, value: val, typed: 1'b0, len: 0,
              levels: '0, hold: '0};
        directed_rows.push_back(r);
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        stim_row_t r;
        r = '{op: ROW_BYTE, reg_idx: uafs_pkg::REG_START_BITS, value: {9'd0, b},
              typed: 1'b0, len: 0, levels: '0, hold: '0};
        directed_rows.push_back(r);
    endfunction

    // Row with its periods typed in: length, level per period (bit 0 first), hold
    function automatic void add_typed(input logic [7:0] b, input int len,
                                      input logic [15:0] levels, input logic [16:0] hold);
        stim_row_t r;
        r = '{op: ROW_BYTE, reg_idx: uafs_pkg::REG_START_BITS, value: {9'd0, b},
              typed: 1'b1, len: len, levels: levels, hold: hold};
        directed_rows.push_back(r);
    endfunction

    // Hold the register write until the transaction, then track it
    task automatic write_reg(input uafs_pkg::cfg_reg_t idx, input logic [16:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            uafs_pkg::REG_START_BITS: frm_start_bits = val[2:0];
            uafs_pkg::REG_DATA_BITS:  frm_data_bits  = val[3:0];
            uafs_pkg::REG_STOP_BITS:  frm_stop_bits  = val[2:0];
            uafs_pkg::REG_BAUD_RATE:  frm_baud_rate  = val;
            default: ;
        endcase
    endtask

    task automatic send_byte(input stim_row_t r);
        int      gap;
        period_t p;
        cfg_valid <= 1'b0;
        gap = tx_burst ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push    <= 1'b1;
        tx_byte <= r.value[7:0];
        do
            @(posedge clk);
        while (full);
        bytes_sent++;
        if (r.typed)
        begin
            for (int k = 0; k < r.len; k++)
            begin
                p = '{level: r.levels[k], hold: r.hold, last: (k == r.len - 1)};
                expected_periods.push_back(p);
            end
        end
        else
            predict_frame(r.value[7:0]);
    endtask

    // Drop both request lines and wait for every outstanding period
    task automatic wait_drained();
        push      <= 1'b0;
        cfg_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_periods.size() != 0);
    endtask

    task automatic check_period();
        period_t want;
        if (expected_periods.size() == 0)
        begin
            report_mismatch($sformatf("unexpected period level=%0b hold=%0d end=%0b",
                                      line_level, hold_ns, frame_end));
            return;
        end
        want = expected_periods.pop_front();
        if (line_level !== want.level)
            report_mismatch($sformatf("line_level %0b, want %0b", line_level, want.level));
        if (hold_ns !== want.hold)
            report_mismatch($sformatf("hold_ns %0d, want %0d", hold_ns, want.hold));
        if (frame_end !== want.last)
            report_mismatch($sformatf("frame_end %0b, want %0b", frame_end, want.last));
    endtask

    // Result side: random stalls, burst stretches and one long hold-off
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                pop <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                gap = rx_burst ? 0 : $urandom_range(0, 3);
                if (gap > 0)
                begin
                    pop <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty && !hold_req);
            if (!empty)
                check_period();
        end
    end

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        stim_row_t r;
        int        phase;
        int        n_items;

        frm_start_bits = uafs_pkg::RST_START_BITS;
        frm_data_bits  = uafs_pkg::RST_DATA_BITS;
        frm_stop_bits  = uafs_pkg::RST_STOP_BITS;
        frm_baud_rate  = uafs_pkg::RST_BAUD_RATE;

        add_typed(8'h00, 10, 16'h01FF, uafs_pkg::HOLD_19200);
        add_typed(8'hFF, 10, 16'h0001, uafs_pkg::HOLD_19200);
        add_byte(8'hA5);
        add_cfg(uafs_pkg::REG_BAUD_RATE, uafs_pkg::BAUD_9600);
        add_typed(8'h55, 10, 16'h0155, uafs_pkg::HOLD_9600);
        add_byte(8'hC3);
        add_cfg(uafs_pkg::REG_BAUD_RATE, uafs_pkg::BAUD_28800);
        add_byte(8'h3C);
        // unlisted rates fall back to the 19200 hold time
        add_cfg(uafs_pkg::REG_BAUD_RATE, 17'd0);
        add_byte(8'h81);
        add_cfg(uafs_pkg::REG_BAUD_RATE, 17'h1FFFF);
        add_byte(8'h7E);
        // zero counts act as one
        add_cfg(uafs_pkg::REG_START_BITS, 17'd0);
        add_cfg(uafs_pkg::REG_DATA_BITS, 17'd0);
        add_cfg(uafs_pkg::REG_STOP_BITS, 17'd0);
        add_typed(8'h01, 3, 16'h0001, uafs_pkg::HOLD_19200);
        add_typed(8'h00, 3, 16'h0003, uafs_pkg::HOLD_19200);
        // oversized counts clamp to 4 / 8 / 4
        add_cfg(uafs_pkg::REG_START_BITS, 17'd7);
        add_cfg(uafs_pkg::REG_DATA_BITS, 17'd15);
        add_cfg(uafs_pkg::REG_STOP_BITS, 17'd7);
        add_typed(8'h00, 16, 16'h0FFF, uafs_pkg::HOLD_19200);
        add_typed(8'hFF, 16, 16'h000F, uafs_pkg::HOLD_19200);
        add_cfg(uafs_pkg::REG_START_BITS, 17'd4);
        add_cfg(uafs_pkg::REG_DATA_BITS, 17'd8);
        add_cfg(uafs_pkg::REG_STOP_BITS, 17'd4);
        add_byte(8'h96);
        add_cfg(uafs_pkg::REG_START_BITS, 17'd5);
        add_cfg(uafs_pkg::REG_DATA_BITS, 17'd9);
        add_cfg(uafs_pkg::REG_STOP_BITS, 17'd6);
        add_byte(8'h69);
        add_cfg(uafs_pkg::REG_START_BITS, 17'd3);
        add_cfg(uafs_pkg::REG_DATA_BITS, 17'd5);
        add_cfg(uafs_pkg::REG_STOP_BITS, 17'd2);
        add_cfg(uafs_pkg::REG_BAUD_RATE, uafs_pkg::BAUD_19200);
        add_byte(8'hC3);
        add_byte(8'h5A);
        add_cfg(uafs_pkg::REG_START_BITS, 17'd2);
        add_cfg(uafs_pkg::REG_DATA_BITS, 17'd1);
        add_cfg(uafs_pkg::REG_STOP_BITS, 17'd3);
        add_cfg(uafs_pkg::REG_BAUD_RATE, uafs_pkg::BAUD_28800);
        add_byte(8'h01);
        add_byte(8'hFE);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].op == ROW_CFG)
            begin
                wait_drained();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
            end
            else
                send_byte(directed_rows[i]);
        end

        phase = 0;
        while (bytes_sent < TOTAL_ITEMS)
        begin
            wait_drained();
            if ($urandom_range(0, 3) != 0)
                write_reg(uafs_pkg::REG_START_BITS, 17'($urandom_range(0, 7)));
            if ($urandom_range(0, 3) != 0)
                write_reg(uafs_pkg::REG_DATA_BITS, 17'($urandom_range(0, 15)));
            if ($urandom_range(0, 3) != 0)
                write_reg(uafs_pkg::REG_STOP_BITS, 17'($urandom_range(0, 7)));
            if ($urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 6))
                    0: write_reg(uafs_pkg::REG_BAUD_RATE, uafs_pkg::BAUD_9600);
                    1: write_reg(uafs_pkg::REG_BAUD_RATE, uafs_pkg::BAUD_19200);
                    2: write_reg(uafs_pkg::REG_BAUD_RATE, uafs_pkg::BAUD_28800);
                    3: write_reg(uafs_pkg::REG_BAUD_RATE, 17'h1FFFF);
                    4: write_reg(uafs_pkg::REG_BAUD_RATE, 17'd0);
                    5: write_reg(uafs_pkg::REG_BAUD_RATE, 17'd115200);
                    default: write_reg(uafs_pkg::REG_BAUD_RATE,
                                       17'($urandom_range(0, 17'h1FFFF)));
                endcase
            end
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            n_items  = $urandom_range(8, 30);
            // back up the output while bytes keep coming, so intake stalls
            if (phase == 2)
            begin
                hold_req = 1'b1;
                tx_burst = 1'b1;
                n_items  = 20;
            end
            for (int k = 0; k < n_items; k++)
            begin
                r = '{op: ROW_BYTE, reg_idx: uafs_pkg::REG_START_BITS, value: '0,
                      typed: 1'b0, len: 0, levels: '0, hold: '0};
                case ($urandom_range(0, 7))
                    0: r.value = 17'h000;
                    1: r.value = 17'h0FF;
                    default: r.value = 17'($urandom_range(0, 255));
                endcase
                send_byte(r);
            end
            phase++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
sv/uafs_pkg.sv
sv/uafs_front.sv
sv/uafs_queue.sv
sv/uafs_back.sv
sv/uart_frame_serializer.sv
verif/testbench.sv
